@@ rtl/imufs_pkg.sv @@
// ----------------------------------------------------------------------------
// imufs_pkg
// shared constants and types for the imu frame sync parser
// ----------------------------------------------------------------------------
package imufs_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned GAIN_W   = 16;
   localparam int unsigned RESULT_W = 32;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned NUM_AXES = 3;

   localparam logic [BYTE_W-1:0] SYNC_BYTE        = 8'h5A;
   localparam logic [GAIN_W-1:0] ACCEL_GAIN_RESET = 16'd655;
   localparam logic [GAIN_W-1:0] RATE_GAIN_RESET  = 16'd66;

   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_GAIN  = 2'd1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [RESULT_W-1:0] result_type;

   // raw samples of one good frame, handed from the checker to the scaler
   typedef struct packed {
      logic                      valid;
      sample_type [NUM_AXES-1:0] accel;
      sample_type [NUM_AXES-1:0] rate;
   } frame_type;

endpackage

@@ rtl/imu_frame_sync_parser_top.sv @@
// ----------------------------------------------------------------------------
// imu_frame_sync_parser_top
// frame sync, additive checksum and sample scaling for an imu byte stream
// ----------------------------------------------------------------------------
// req_ carries one received byte per beat. the block keeps a sliding window
// of FRAME_LEN bytes; a frame is good when it starts with two 0x5A bytes and
// its last byte equals the 8-bit sum of the others. a bad window drops its
// oldest byte. a good frame gives one rsp_ beat of six Q15.16 samples
// (raw sample times accel_gain or rate_gain) and empties the window.
// csr_ writes the gains (index 0 accel, 1 rate); other indexes are ignored.
// throughput: one byte per cycle while req_ready is high, set by the running checksum register.
// path: the closing byte's beat loads the raw sample register; the multiplier
// result register takes it over whenever that register is empty or its beat
// is taken, and rsp_valid shows that the result register holds a beat.
// if rsp_ready is low, one further good frame is held in the sample register;
// req_ready drops only while both registers are full.
// reset clears the window bytes, window count, checksum, both valid flags
// and sets the gains to their defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module imu_frame_sync_parser_top
   import imufs_pkg::*;
#(
   parameter int unsigned FRAME_LEN = 21
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [RESULT_W-1:0] rsp_accel_x,
   output logic signed [RESULT_W-1:0] rsp_accel_y,
   output logic signed [RESULT_W-1:0] rsp_accel_z,
   output logic signed [RESULT_W-1:0] rsp_rate_x,
   output logic signed [RESULT_W-1:0] rsp_rate_y,
   output logic signed [RESULT_W-1:0] rsp_rate_z,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_wdata
);

   logic [GAIN_W-1:0]         accel_gain_ff;
   logic [GAIN_W-1:0]         rate_gain_ff;
   frame_type                 frame;
   logic                      frame_advance;
   logic                      byte_fire;
   result_type [NUM_AXES-1:0] accel;
   result_type [NUM_AXES-1:0] rate;

   assign req_ready = !frame.valid || frame_advance;
   assign byte_fire = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_gain_ff <= ACCEL_GAIN_RESET;
         rate_gain_ff  <= RATE_GAIN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ACCEL_GAIN: accel_gain_ff <= csr_wdata;
            CSR_RATE_GAIN:  rate_gain_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   imufs_frame_check #(
      .FRAME_LEN(FRAME_LEN)
   ) u_check (
      .clock         (clock),
      .reset         (reset),
      .byte_fire     (byte_fire),
      .rx_byte       (req_rx_byte),
      .frame_advance (frame_advance),
      .frame         (frame)
   );

   imufs_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .frame         (frame),
      .accel_gain    (accel_gain_ff),
      .rate_gain     (rate_gain_ff),
      .frame_advance (frame_advance),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .accel         (accel),
      .rate          (rate)
   );

   assign rsp_accel_x = accel[0];
   assign rsp_accel_y = accel[1];
   assign rsp_accel_z = accel[2];
   assign rsp_rate_x  = rate[0];
   assign rsp_rate_y  = rate[1];
   assign rsp_rate_z  = rate[2];

endmodule

@@ rtl/imufs_frame_check.sv @@
// ----------------------------------------------------------------------------
// imufs_frame_check
// byte window, running checksum, sync and sum check, raw sample register
// ----------------------------------------------------------------------------
module imufs_frame_check
   import imufs_pkg::*;
#(
   parameter int unsigned FRAME_LEN = 21
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_fire,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic              frame_advance,
   output frame_type         frame
);

   localparam int unsigned CNT_W = $clog2(FRAME_LEN);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_LEN - 1);

   // window position 0 is oldest; a new byte enters at the top
   logic [BYTE_W-1:0] win_ff [FRAME_LEN];
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   frame_type         frame_ff, frame_in;
   logic              hit;

   assign hit = byte_fire && (cnt_ff == LAST_CNT) &&
                (win_ff[1] == SYNC_BYTE) && (win_ff[2] == SYNC_BYTE) &&
                (sum_ff == rx_byte);

   // sum of window positions 1 to top after the shift
   assign sum_in = byte_fire ? (sum_ff - win_ff[1] + rx_byte) : sum_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (byte_fire) begin
         if (cnt_ff == LAST_CNT) begin
            cnt_in = hit ? '0 : LAST_CNT;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      frame_in = frame_ff;
      if (frame_advance) begin
         frame_in.valid = 1'b0;
      end
      if (hit) begin
         frame_in.valid = 1'b1;
         for (int k = 0; k < NUM_AXES; k++) begin
            frame_in.accel[k] = {win_ff[3+2*k], win_ff[4+2*k]};
            frame_in.rate[k]  = {win_ff[9+2*k], win_ff[10+2*k]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff         <= '0;
         sum_ff         <= '0;
         frame_ff.valid <= 1'b0;
         for (int i = 0; i < FRAME_LEN; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         frame_ff <= frame_in;
         if (byte_fire) begin
            for (int i = 0; i < FRAME_LEN - 1; i++) begin
               win_ff[i] <= win_ff[i+1];
            end
            win_ff[FRAME_LEN-1] <= rx_byte;
         end
      end
   end

   assign frame = frame_ff;

endmodule

@@ rtl/imufs_scale.sv @@
// ----------------------------------------------------------------------------
// imufs_scale
// gain multipliers and result register
// ----------------------------------------------------------------------------
module imufs_scale
   import imufs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  frame_type           frame,
   input  logic [GAIN_W-1:0]   accel_gain,
   input  logic [GAIN_W-1:0]   rate_gain,
   output logic                frame_advance,
   output logic                out_valid,
   input  logic                out_ready,
   output result_type [NUM_AXES-1:0] accel,
   output result_type [NUM_AXES-1:0] rate
);

   logic                       valid_ff;
   result_type [NUM_AXES-1:0]  accel_ff, accel_in;
   result_type [NUM_AXES-1:0]  rate_ff, rate_in;
   logic signed [RESULT_W-1:0] accel_prod [NUM_AXES];
   logic signed [RESULT_W-1:0] rate_prod [NUM_AXES];

   assign frame_advance = !valid_ff || out_ready;

   // sample sign extended, gain zero extended; the low 32 bits are exact
   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         accel_prod[k] = RESULT_W'(frame.accel[k]) * $signed(RESULT_W'(accel_gain));
         rate_prod[k]  = RESULT_W'(frame.rate[k]) * $signed(RESULT_W'(rate_gain));
         accel_in[k]   = accel_prod[k];
         rate_in[k]    = rate_prod[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (frame_advance) begin
         valid_ff <= frame.valid;
         if (frame.valid) begin
            accel_ff <= accel_in;
            rate_ff  <= rate_in;
         end
      end
   end

   assign out_valid = valid_ff;
   assign accel     = accel_ff;
   assign rate      = rate_ff;

endmodule

@@ rtl/imufs_checker.sv @@
// ----------------------------------------------------------------------------
// imufs_checker
// port-level assertions for the imu frame sync parser
// ----------------------------------------------------------------------------
module imufs_checker
   import imufs_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [RESULT_W-1:0]  rsp_accel_x,
   input logic [RESULT_W-1:0]  rsp_rate_z
);

   // no result beat right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // input stalls only while a result waits on a stalled receiver
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low without output back-pressure");

   // a stalled result beat stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled result beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_accel_x) && $stable(rsp_rate_z)))
      else $error("rsp payload changed while stalled");

endmodule

bind imu_frame_sync_parser_top imufs_checker u_imufs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_accel_x (rsp_accel_x),
   .rsp_rate_z  (rsp_rate_z)
);

@@ verif/imufs_sample_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imufs_sample_check
// follows the accepted byte stream, keeps its own frame window and gains,
// predicts the six scaled samples of every good frame and compares each
// rsp_ beat, field by field, with the oldest prediction still open
// ----------------------------------------------------------------------------
module imufs_sample_check
   import imufs_pkg::*;
#(
   parameter int unsigned FRAME_LEN = 21
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [BYTE_W-1:0]          req_rx_byte,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [RESULT_W-1:0] rsp_accel_x,
   input  logic signed [RESULT_W-1:0] rsp_accel_y,
   input  logic signed [RESULT_W-1:0] rsp_accel_z,
   input  logic signed [RESULT_W-1:0] rsp_rate_x,
   input  logic signed [RESULT_W-1:0] rsp_rate_y,
   input  logic signed [RESULT_W-1:0] rsp_rate_z,
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [GAIN_W-1:0]          csr_wdata,
   output int                         error_count,
   output int                         outstanding,
   output int                         checked_count
);

   localparam int unsigned NUM_FIELDS = 2 * NUM_AXES;

   // index 0 is accel_x, index NUM_FIELDS-1 is rate_z
   typedef result_type [NUM_FIELDS-1:0] sample_set_type;

   logic [BYTE_W-1:0] window [FRAME_LEN];
   int unsigned       held;
   logic [GAIN_W-1:0] accel_gain;
   logic [GAIN_W-1:0] rate_gain;
   sample_set_type    pending_samples [$];
   int                mismatches;
   int                matched;
   string             field_name [NUM_FIELDS] =
      '{"accel_x", "accel_y", "accel_z", "rate_x", "rate_y", "rate_z"};

   function automatic result_type scale_raw(input int unsigned pos,
                                            input logic [GAIN_W-1:0] gain);
      sample_type raw;
      result_type wide_raw;
      result_type wide_gain;
      raw       = {window[pos], window[pos+1]};
      wide_raw  = raw;
      wide_gain = {{(RESULT_W-GAIN_W){1'b0}}, gain};
      return wide_raw * wide_gain;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic track_byte(input logic [BYTE_W-1:0] rx);
      logic [BYTE_W-1:0] sum;
      sample_set_type    want;
      window[held] = rx;
      held++;
      if (held < FRAME_LEN) return;
      sum = '0;
      for (int i = 0; i < FRAME_LEN - 1; i++) sum += window[i];
      if (window[0] != SYNC_BYTE || window[1] != SYNC_BYTE || sum != window[FRAME_LEN-1]) begin
         // slide by one byte and keep scanning
         for (int i = 0; i < FRAME_LEN - 1; i++) window[i] = window[i+1];
         held = FRAME_LEN - 1;
      end else begin
         for (int a = 0; a < NUM_AXES; a++) begin
            want[a]          = scale_raw(2 + 2 * a, accel_gain);
            want[NUM_AXES+a] = scale_raw(2 + 2 * (NUM_AXES + a), rate_gain);
         end
         pending_samples.push_back(want);
         held = 0;
      end
   endtask

   task automatic check_beat();
      sample_set_type seen;
      sample_set_type want;
      seen = {rsp_rate_z, rsp_rate_y, rsp_rate_x, rsp_accel_z, rsp_accel_y, rsp_accel_x};
      if (pending_samples.size() == 0) begin
         report_mismatch("result beat with no good frame outstanding");
      end else begin
         want = pending_samples.pop_front();
         for (int i = 0; i < NUM_FIELDS; i++) begin
            if (seen[i] !== want[i]) begin
               report_mismatch($sformatf("%s got %0d expected %0d", field_name[i],
                                         $signed(seen[i]), $signed(want[i])));
            end
         end
         matched++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held       = 0;
         accel_gain = ACCEL_GAIN_RESET;
         rate_gain  = RATE_GAIN_RESET;
         pending_samples.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ACCEL_GAIN: accel_gain = csr_wdata;
               CSR_RATE_GAIN:  rate_gain  = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) check_beat();
         if (req_valid && req_ready) track_byte(req_rx_byte);
      end
      outstanding   <= pending_samples.size();
      error_count   <= mismatches;
      checked_count <= matched;
   end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// byte stream regression for the imu frame sync parser: a directed extreme
// frame, then random good, corrupted, truncated and noise segments under
// several gain settings, with bursty sending and patterned result stalls
// ----------------------------------------------------------------------------
module tb;
   import imufs_pkg::*;

   localparam int unsigned FRAME_LEN      = 21;
   localparam int unsigned SETTLE_CYCLES  = 6;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned NUM_PHASES     = 6;
   localparam int unsigned PHASE_BYTES    = 90;
   localparam int unsigned PHASE_FRAMES   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   // index 0 is the first sample of the frame
   localparam logic [5:0][SAMPLE_W-1:0] EXTREME_SAMPLES =
      {16'h8001, 16'h0001, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF};

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_type;
   typedef enum {SEG_GOOD, SEG_BAD_SUM, SEG_BAD_SYNC, SEG_NOISE, SEG_CUT} segment_type;

   logic                       clock;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_ready;
   logic [BYTE_W-1:0]          req_rx_byte = '0;
   logic                       rsp_valid;
   logic                       rsp_ready   = 1'b0;
   logic signed [RESULT_W-1:0] rsp_accel_x;
   logic signed [RESULT_W-1:0] rsp_accel_y;
   logic signed [RESULT_W-1:0] rsp_accel_z;
   logic signed [RESULT_W-1:0] rsp_rate_x;
   logic signed [RESULT_W-1:0] rsp_rate_y;
   logic signed [RESULT_W-1:0] rsp_rate_z;
   logic                       csr_write   = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index   = '0;
   logic [GAIN_W-1:0]          csr_wdata   = '0;

   int error_count;
   int outstanding;
   int checked_count;

   logic [BYTE_W-1:0] frame_buf [FRAME_LEN];
   int                burst_left;
   int                bytes_sent;
   int                frames_sent;
   int                settings_used = 1;
   int                idle_cycles;
   rx_mode_type       rx_mode = RX_OPEN;
   int unsigned       rx_tick;

   imu_frame_sync_parser_top #(
      .FRAME_LEN (FRAME_LEN)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_accel_x (rsp_accel_x),
      .rsp_accel_y (rsp_accel_y),
      .rsp_accel_z (rsp_accel_z),
      .rsp_rate_x  (rsp_rate_x),
      .rsp_rate_y  (rsp_rate_y),
      .rsp_rate_z  (rsp_rate_z),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   imufs_sample_check #(
      .FRAME_LEN (FRAME_LEN)
   ) i_sample_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_accel_x   (rsp_accel_x),
      .rsp_accel_y   (rsp_accel_y),
      .rsp_accel_z   (rsp_accel_z),
      .rsp_rate_x    (rsp_rate_x),
      .rsp_rate_y    (rsp_rate_y),
      .rsp_rate_z    (rsp_rate_z),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .outstanding   (outstanding),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stall pattern, drawn at random from four modes
   always @(posedge clock) begin
      rx_tick = rx_tick + 1;
      if (rx_tick % 64 == 0) begin
         case ($urandom_range(0, 3))
            0:       rx_mode = RX_OPEN;
            1:       rx_mode = RX_COIN;
            2:       rx_mode = RX_SPARSE;
            default: rx_mode = RX_COMB;
         endcase
      end
      case (rx_mode)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
         RX_SPARSE: rsp_ready <= ($urandom_range(0, 7) == 0);
         default:   rsp_ready <= (rx_tick % 4 == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", idle_cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'hFFFF;
         3:       return 16'h0001;
         default: return SAMPLE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic make_frame(input bit extreme);
      logic [SAMPLE_W-1:0] s;
      logic [BYTE_W-1:0]   sum;
      frame_buf[0] = SYNC_BYTE;
      frame_buf[1] = SYNC_BYTE;
      for (int a = 0; a < 2 * NUM_AXES; a++) begin
         s = extreme ? EXTREME_SAMPLES[a] : pick_sample();
         frame_buf[2+2*a] = s[15:8];
         frame_buf[3+2*a] = s[7:0];
      end
      for (int i = 2 + 4 * NUM_AXES; i < FRAME_LEN - 1; i++) begin
         frame_buf[i] = BYTE_W'($urandom_range(0, 255));
      end
      sum = '0;
      for (int i = 0; i < FRAME_LEN - 1; i++) sum += frame_buf[i];
      frame_buf[FRAME_LEN-1] = sum;
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] rx);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input int count);
      for (int i = 0; i < count; i++) send_byte(frame_buf[i]);
   endtask

   // sender stops until every predicted result has come out
   task automatic wait_idle();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic program_gains(input int phase);
      logic [GAIN_W-1:0] a_gain;
      logic [GAIN_W-1:0] r_gain;
      a_gain = GAIN_W'($urandom_range(0, 65535));
      r_gain = GAIN_W'($urandom_range(0, 65535));
      case (phase)
         1: begin
            a_gain = '0;
            r_gain = '0;
         end
         2: begin
            a_gain = '1;
            r_gain = '1;
         end
         3: begin
            a_gain = 16'd1;
            r_gain = 16'h8000;
         end
         5: begin
            a_gain = '1;
            r_gain = '0;
         end
         default: ;
      endcase
      write_reg(CSR_ACCEL_GAIN, a_gain);
      write_reg(CSR_RATE_GAIN, r_gain);
      // spare indexes must leave both gains alone
      write_reg((phase % 2 == 0) ? CSR_SPARE_A : CSR_SPARE_B,
                GAIN_W'($urandom_range(0, 65535)));
      csr_write <= 1'b0;
      settings_used++;
   endtask

   task automatic run_segment();
      segment_type kind;
      case ($urandom_range(0, 9))
         6:       kind = SEG_BAD_SUM;
         7:       kind = SEG_BAD_SYNC;
         8:       kind = SEG_NOISE;
         9:       kind = SEG_CUT;
         default: kind = SEG_GOOD;
      endcase
      case (kind)
         SEG_GOOD: begin
            make_frame(1'b0);
            send_frame(FRAME_LEN);
            frames_sent++;
         end
         SEG_BAD_SUM: begin
            make_frame(1'b0);
            frame_buf[FRAME_LEN-1] ^= BYTE_W'($urandom_range(1, 255));
            send_frame(FRAME_LEN);
         end
         SEG_BAD_SYNC: begin
            make_frame(1'b0);
            frame_buf[$urandom_range(0, 1)] ^= BYTE_W'($urandom_range(1, 255));
            send_frame(FRAME_LEN);
         end
         SEG_NOISE: begin
            repeat ($urandom_range(1, 6)) begin
               send_byte(($urandom_range(0, 1) == 1) ? SYNC_BYTE
                                                     : BYTE_W'($urandom_range(0, 255)));
            end
         end
         default: begin
            make_frame(1'b0);
            send_frame($urandom_range(1, FRAME_LEN - 1));
         end
      endcase
   endtask

   initial begin
      int bytes_at_start;
      int frames_at_start;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // extremes of the byte, a leading sync byte that must be skipped,
      // then a frame of extreme samples under the reset gains
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(SYNC_BYTE);
      make_frame(1'b1);
      send_frame(FRAME_LEN);
      frames_sent++;

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            wait_idle();
            program_gains(p);
         end
         bytes_at_start  = bytes_sent;
         frames_at_start = frames_sent;
         while (bytes_sent - bytes_at_start < PHASE_BYTES ||
                frames_sent - frames_at_start < PHASE_FRAMES) begin
            run_segment();
         end
      end

      wait_idle();
      $display("streamed %0d bytes holding %0d intended frames under %0d gain settings",
               bytes_sent, frames_sent, settings_used);
      $display("%0d result beats checked against prediction with bursty input and stalls",
               checked_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ imu_frame_sync_parser_top.f @@
rtl/imufs_pkg.sv
rtl/imufs_frame_check.sv
rtl/imufs_scale.sv
rtl/imu_frame_sync_parser_top.sv
rtl/imufs_checker.sv
verif/imufs_sample_check.sv
verif/tb.sv
